// File: sv/assert_macros.svh
// Assertion macros shared by the linear queue modules.
// Each macro expects clk and arst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every clock edge out of reset.
`define LQR_HOLD(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define LQR_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define LQR_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/lqr_pkg.sv
// Shared types and constants for the linear queue with reverse.
// No dependencies; used by lqr_ctrl, lqr_datapath and the top level.
`timescale 1ns / 1ps

package lqr_pkg;

	localparam int DEPTH    = 8;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int WORD_W   = 32;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int HELD_W   = 4;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	// Operation codes of an input item
	typedef enum logic [KIND_W-1:0] {
		KIND_ENQ = 2'd0,
		KIND_DEQ = 2'd1,
		KIND_REV = 2'd2
	} kind_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		RES_DONE  = 2'd0,
		RES_FULL  = 2'd1,
		RES_EMPTY = 2'd2
	} result_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DEQ_POP,
		ST_SWAP_RD,
		ST_SWAP_WLO,
		ST_SWAP_WHI,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_REV_FIN,
		ST_RESP
	} fsm_state_t;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		DP_NOP,
		DP_ENQ,
		DP_ENQ_FULL,
		DP_DEQ_RD,
		DP_DEQ_POP,
		DP_DEQ_EMPTY,
		DP_SWAP_INIT,
		DP_SWAP_RD,
		DP_SWAP_WLO,
		DP_SWAP_WHI,
		DP_SHIFT_INIT,
		DP_SHIFT_RD,
		DP_SHIFT_WR,
		DP_REV_DONE,
		DP_RESP
	} dp_op_t;

	// Controller to datapath
	typedef struct packed {
		logic   accept;
		dp_op_t op;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		kind_t kind;
		logic  empty;
		logic  full;
		logic  swap_done;
		logic  head_zero;
		logic  shift_last;
		logic  out_free;
	} sts_t;

endpackage

// File: sv/lqr_ctrl.sv
// Controller state machine for the linear queue with reverse.
// Depends on lqr_pkg and assert_macros.svh; drives lqr_datapath by command.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lqr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  lqr_pkg::sts_t   sts,
	output lqr_pkg::cmd_t   cmd
);

	lqr_pkg::fsm_state_t state_q;
	lqr_pkg::fsm_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lqr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d    = state_q;
		cmd.accept = 1'b0;
		cmd.op     = lqr_pkg::DP_NOP;
		in_stall   = (state_q != lqr_pkg::ST_IDLE);
		case (state_q)
			lqr_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = lqr_pkg::ST_EXEC;
				end
			end
			lqr_pkg::ST_EXEC: begin
				case (sts.kind)
					lqr_pkg::KIND_ENQ: begin
						cmd.op  = sts.full ? lqr_pkg::DP_ENQ_FULL : lqr_pkg::DP_ENQ;
						state_d = lqr_pkg::ST_RESP;
					end
					lqr_pkg::KIND_DEQ: begin
						if (sts.empty) begin
							cmd.op  = lqr_pkg::DP_DEQ_EMPTY;
							state_d = lqr_pkg::ST_RESP;
						end else begin
							cmd.op  = lqr_pkg::DP_DEQ_RD;
							state_d = lqr_pkg::ST_DEQ_POP;
						end
					end
					lqr_pkg::KIND_REV: begin
						if (sts.empty) begin
							state_d = lqr_pkg::ST_RESP;
						end else begin
							cmd.op  = lqr_pkg::DP_SWAP_INIT;
							state_d = lqr_pkg::ST_SWAP_RD;
						end
					end
					default: begin
						state_d = lqr_pkg::ST_RESP;
					end
				endcase
			end
			lqr_pkg::ST_DEQ_POP: begin
				cmd.op  = lqr_pkg::DP_DEQ_POP;
				state_d = lqr_pkg::ST_RESP;
			end
			// Swap pairs from both ends inward, then move the block down to slot 0 unless it starts there
			lqr_pkg::ST_SWAP_RD: begin
				if (!sts.swap_done) begin
					cmd.op  = lqr_pkg::DP_SWAP_RD;
					state_d = lqr_pkg::ST_SWAP_WLO;
				end else if (sts.head_zero) begin
					cmd.op  = lqr_pkg::DP_REV_DONE;
					state_d = lqr_pkg::ST_RESP;
				end else begin
					cmd.op  = lqr_pkg::DP_SHIFT_INIT;
					state_d = lqr_pkg::ST_SHIFT_RD;
				end
			end
			lqr_pkg::ST_SWAP_WLO: begin
				cmd.op  = lqr_pkg::DP_SWAP_WLO;
				state_d = lqr_pkg::ST_SWAP_WHI;
			end
			lqr_pkg::ST_SWAP_WHI: begin
				cmd.op  = lqr_pkg::DP_SWAP_WHI;
				state_d = lqr_pkg::ST_SWAP_RD;
			end
			lqr_pkg::ST_SHIFT_RD: begin
				cmd.op  = lqr_pkg::DP_SHIFT_RD;
				state_d = lqr_pkg::ST_SHIFT_WR;
			end
			lqr_pkg::ST_SHIFT_WR: begin
				cmd.op  = lqr_pkg::DP_SHIFT_WR;
				state_d = sts.shift_last ? lqr_pkg::ST_REV_FIN : lqr_pkg::ST_SHIFT_RD;
			end
			lqr_pkg::ST_REV_FIN: begin
				cmd.op  = lqr_pkg::DP_REV_DONE;
				state_d = lqr_pkg::ST_RESP;
			end
			// Hold the result until the output register is free
			lqr_pkg::ST_RESP: begin
				if (sts.out_free) begin
					cmd.op  = lqr_pkg::DP_RESP;
					state_d = lqr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lqr_pkg::ST_IDLE;
			end
		endcase
	end

	`LQR_NEXT(a_accept_exec, in_valid && !in_stall, state_q == lqr_pkg::ST_EXEC, "accepted item did not start execution")
	`LQR_NEXT(a_resp_idle, (state_q == lqr_pkg::ST_RESP) && sts.out_free, state_q == lqr_pkg::ST_IDLE, "response did not retire")
	`LQR_NEXT(a_swap_loop, state_q == lqr_pkg::ST_SWAP_WHI, state_q == lqr_pkg::ST_SWAP_RD, "swap pair did not return to read")

endmodule

// File: sv/lqr_datapath.sv
// Datapath for the linear queue with reverse: slot memory, indices, result registers.
// Depends on lqr_pkg and assert_macros.svh; sequenced by lqr_ctrl.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lqr_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lqr_pkg::cmd_t                         cmd,
	output lqr_pkg::sts_t                         sts,
	input  logic [lqr_pkg::KIND_W-1:0]            kind,
	input  logic signed [lqr_pkg::WORD_W-1:0]     value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [lqr_pkg::WORD_W-1:0]     word_out,
	output logic [lqr_pkg::STATUS_W-1:0]          status,
	output logic [lqr_pkg::HELD_W-1:0]            held_count
);

	// Slot memory and its registered read ports
	logic signed [lqr_pkg::WORD_W-1:0] mem [lqr_pkg::DEPTH];
	logic signed [lqr_pkg::WORD_W-1:0] rd_a_q;
	logic signed [lqr_pkg::WORD_W-1:0] rd_b_q;

	// Queue indices and work indices
	logic [lqr_pkg::IDX_W-1:0] head_q;
	logic [lqr_pkg::IDX_W-1:0] tail_q;
	logic                      empty_q;
	logic [lqr_pkg::IDX_W-1:0] lo_q;
	logic [lqr_pkg::IDX_W-1:0] hi_q;

	// Latched item and result
	lqr_pkg::kind_t                    kind_q;
	logic signed [lqr_pkg::WORD_W-1:0] value_q;
	logic signed [lqr_pkg::WORD_W-1:0] word_q;
	lqr_pkg::result_t                  result_q;

	// Output register
	logic                              out_valid_q;
	logic signed [lqr_pkg::WORD_W-1:0] out_word_q;
	lqr_pkg::result_t                  out_status_q;
	logic [lqr_pkg::HELD_W-1:0]        out_held_q;

	logic                              wr_en;
	logic [lqr_pkg::IDX_W-1:0]         wr_addr;
	logic signed [lqr_pkg::WORD_W-1:0] wr_data;
	logic                              rd_en_a;
	logic                              rd_en_b;
	logic [lqr_pkg::IDX_W-1:0]         rd_addr_a;
	logic [lqr_pkg::CNT_W-1:0]         held;

	// Select memory port addresses and data per operation
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = lo_q;
		wr_data   = rd_b_q;
		rd_en_a   = 1'b0;
		rd_en_b   = 1'b0;
		rd_addr_a = lo_q;
		case (cmd.op)
			lqr_pkg::DP_ENQ: begin
				wr_en   = 1'b1;
				wr_addr = empty_q ? '0 : tail_q + 1'b1;
				wr_data = value_q;
			end
			lqr_pkg::DP_DEQ_RD: begin
				rd_en_a   = 1'b1;
				rd_addr_a = head_q;
			end
			lqr_pkg::DP_SWAP_RD: begin
				rd_en_a   = 1'b1;
				rd_en_b   = 1'b1;
				rd_addr_a = lo_q;
			end
			lqr_pkg::DP_SWAP_WLO: begin
				wr_en   = 1'b1;
				wr_addr = lo_q;
				wr_data = rd_b_q;
			end
			lqr_pkg::DP_SWAP_WHI: begin
				wr_en   = 1'b1;
				wr_addr = hi_q;
				wr_data = rd_a_q;
			end
			lqr_pkg::DP_SHIFT_RD: begin
				rd_en_a   = 1'b1;
				rd_addr_a = hi_q;
			end
			lqr_pkg::DP_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_addr = lo_q;
				wr_data = rd_a_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en_a) begin
			rd_a_q <= mem[rd_addr_a];
		end
		if (rd_en_b) begin
			rd_b_q <= mem[hi_q];
		end
	end

	// Advance queue and work indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
			lo_q    <= '0;
			hi_q    <= '0;
		end else begin
			case (cmd.op)
				lqr_pkg::DP_ENQ: begin
					if (empty_q) begin
						head_q  <= '0;
						tail_q  <= '0;
						empty_q <= 1'b0;
					end else begin
						tail_q <= tail_q + 1'b1;
					end
				end
				lqr_pkg::DP_DEQ_POP: begin
					if (head_q == tail_q) begin
						head_q  <= '0;
						tail_q  <= '0;
						empty_q <= 1'b1;
					end else begin
						head_q <= head_q + 1'b1;
					end
				end
				lqr_pkg::DP_SWAP_INIT: begin
					lo_q <= head_q;
					hi_q <= tail_q;
				end
				lqr_pkg::DP_SWAP_WHI: begin
					lo_q <= lo_q + 1'b1;
					hi_q <= hi_q - 1'b1;
				end
				lqr_pkg::DP_SHIFT_INIT: begin
					lo_q <= '0;
					hi_q <= head_q;
				end
				lqr_pkg::DP_SHIFT_WR: begin
					lo_q <= lo_q + 1'b1;
					hi_q <= hi_q + 1'b1;
				end
				lqr_pkg::DP_REV_DONE: begin
					tail_q <= tail_q - head_q;
					head_q <= '0;
				end
				default: begin
					head_q <= head_q;
				end
			endcase
		end
	end

	// Capture the item and build its result
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q   <= lqr_pkg::kind_t'(kind);
			value_q  <= value;
			word_q   <= '0;
			result_q <= lqr_pkg::RES_DONE;
		end else begin
			case (cmd.op)
				lqr_pkg::DP_ENQ_FULL:  result_q <= lqr_pkg::RES_FULL;
				lqr_pkg::DP_DEQ_EMPTY: result_q <= lqr_pkg::RES_EMPTY;
				lqr_pkg::DP_DEQ_POP:   word_q   <= rd_a_q;
				default:               word_q   <= word_q;
			endcase
		end
	end

	// Words held after the operation
	assign held = empty_q ? '0
		: lqr_pkg::CNT_W'(tail_q) - lqr_pkg::CNT_W'(head_q) + 1'b1;

	// Output register: load on response, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == lqr_pkg::DP_RESP) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == lqr_pkg::DP_RESP) begin
			out_word_q   <= word_q;
			out_status_q <= result_q;
			out_held_q   <= lqr_pkg::HELD_W'(held);
		end
	end

	assign out_valid  = out_valid_q;
	assign word_out   = out_word_q;
	assign status     = out_status_q;
	assign held_count = out_held_q;

	// Status back to the controller
	assign sts.kind       = kind_q;
	assign sts.empty      = empty_q;
	assign sts.full       = !empty_q && (tail_q == lqr_pkg::LAST_IDX);
	assign sts.swap_done  = !(lo_q < hi_q);
	assign sts.head_zero  = (head_q == '0);
	assign sts.shift_last = (hi_q == tail_q);
	assign sts.out_free   = !out_valid_q || !out_stall;

	`LQR_IMPLY(a_empty_idx, empty_q, (head_q == '0) && (tail_q == '0), "empty queue with nonzero indices")
	`LQR_HOLD(a_idx_order, empty_q || (tail_q >= head_q), "tail below head")
	`LQR_NEXT(a_rev_head, cmd.op == lqr_pkg::DP_REV_DONE, (head_q == '0) && !empty_q, "reverse left head off slot zero")

endmodule

// File: sv/linear_queue_with_reverse_core.sv
// Linear queue with reverse: an enqueue appends at the tail; a dequeue reads the head slot,
// then pops it. A reverse swaps pairs from both ends inward through the single shared
// memory write port, then moves the block down to slot 0 when the head is not there.
// One item is in flight at a time. The result waits in an output register and the next item
// can be taken the cycle after it is loaded. Reset (arst_n low) empties the queue and clears
// out_valid; slot contents stay undefined. Depends on lqr_pkg, lqr_ctrl and lqr_datapath.
`timescale 1ns / 1ps

module linear_queue_with_reverse_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lqr_pkg::KIND_W-1:0]        kind,
	input  logic signed [lqr_pkg::WORD_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [lqr_pkg::WORD_W-1:0] word_out,
	output logic [lqr_pkg::STATUS_W-1:0]      status,
	output logic [lqr_pkg::HELD_W-1:0]        held_count
);

	lqr_pkg::cmd_t cmd;
	lqr_pkg::sts_t sts;

	// Sequence each operation
	lqr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold slots, indices and the result
	lqr_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.kind       (kind),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.word_out   (word_out),
		.status     (status),
		.held_count (held_count)
	);

endmodule
